// File: sv/slcd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sync/length/checksum deframer.
// No dependencies; used by slcd_out_fifo and sync_length_checksum_deframer.
package slcd_pkg;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_FIRST   = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND  = 2'd1;
  localparam logic [1:0] REG_CHECK_ENABLE = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd170;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd85;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        frame_ok;
    logic [15:0] frame_length;
  } result_t;

  // Up to two results pushed per accepted byte; second only with the first.
  typedef struct packed {
    logic    en0;
    logic    en1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

// File: sv/slcd_out_fifo.sv
`timescale 1ns / 1ps
// Result queue: takes up to two results a cycle, gives one unless stalled.
// Depends on slcd_pkg.
module slcd_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  slcd_pkg::push_t     push,
  output logic                nearly_full,
  output logic                out_valid,
  input  logic                out_stall,
  output slcd_pkg::result_t   out_data
);

  slcd_pkg::result_t                  mem_r [slcd_pkg::FIFO_DEPTH];
  logic [slcd_pkg::FIFO_AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [slcd_pkg::FIFO_AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [slcd_pkg::FIFO_CW-1:0]       count_r, count_nxt;
  logic [slcd_pkg::FIFO_CW-1:0]       push_cnt;
  logic                               pop;

  assign out_valid   = (count_r != '0);
  assign out_data    = mem_r[rd_ptr_r];
  assign pop         = out_valid && !out_stall;
  // room for two more results is needed before taking a byte
  assign nearly_full = (count_r > slcd_pkg::FIFO_CW'(slcd_pkg::FIFO_DEPTH - 2));

  always_comb begin
    push_cnt   = slcd_pkg::FIFO_CW'(push.en0) + slcd_pkg::FIFO_CW'(push.en1);
    wr_ptr_nxt = wr_ptr_r + slcd_pkg::FIFO_AW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + slcd_pkg::FIFO_AW'(pop);
    count_nxt  = count_r + push_cnt - slcd_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.en0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.en1) begin
      mem_r[wr_ptr_r + slcd_pkg::FIFO_AW'(1)] <= push.r1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= slcd_pkg::FIFO_CW'(slcd_pkg::FIFO_DEPTH))
    else $error("result queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r + push_cnt) <= slcd_pkg::FIFO_CW'(slcd_pkg::FIFO_DEPTH) + slcd_pkg::FIFO_CW'(0))
    else $error("result queue overflow");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.en1 |-> push.en0)
    else $error("second result pushed without first");

endmodule

// File: sv/sync_length_checksum_deframer.sv
`timescale 1ns / 1ps
// Sync/length/checksum deframer, top level. Depends on slcd_pkg and slcd_out_fifo.
// Results enter the result queue when their byte is taken and leave its head on out_*.
// Throughput: one byte per cycle; in_stall rises only when the four-entry result
// queue holds more than two results (the output side is stalling).
// Reset (rst_n low, synchronous): hunting, queue empty, registers 170 / 85 / 1.
module sync_length_checksum_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // received byte beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_frame_ok,
  output logic [15:0] out_frame_length
);

  // configuration registers
  logic [7:0]  sync_first_r;
  logic [7:0]  sync_second_r;
  logic        check_enable_r;

  // frame state
  slcd_pkg::phase_t phase_r, phase_nxt;
  logic        saw_first_r, saw_first_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  sum_r, sum_nxt;

  logic              in_fire;
  logic              nearly_full;
  logic [15:0]       len_lo_val;
  logic              sync_hit;
  slcd_pkg::push_t   push;
  slcd_pkg::result_t head;

  assign in_stall   = nearly_full;
  assign in_fire    = in_valid && !in_stall;
  assign len_lo_val = {length_r[15:8], in_rx_byte};
  assign sync_hit   = saw_first_r && (in_rx_byte == sync_second_r);

  // Configuration: writes are taken at once; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r   <= slcd_pkg::SYNC_FIRST_RST;
      sync_second_r  <= slcd_pkg::SYNC_SECOND_RST;
      check_enable_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        slcd_pkg::REG_SYNC_FIRST:   sync_first_r   <= cfg_data;
        slcd_pkg::REG_SYNC_SECOND:  sync_second_r  <= cfg_data;
        slcd_pkg::REG_CHECK_ENABLE: check_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next phase. Unused phase codes fall back to hunting.
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      unique case (phase_r)
        slcd_pkg::PH_LEN_HI: phase_nxt = slcd_pkg::PH_LEN_LO;
        slcd_pkg::PH_LEN_LO: begin
          if (len_lo_val != 16'd0) begin
            phase_nxt = slcd_pkg::PH_PAYLOAD;
          end else if (check_enable_r) begin
            phase_nxt = slcd_pkg::PH_CHECK;
          end else begin
            phase_nxt = slcd_pkg::PH_HUNT;
          end
        end
        slcd_pkg::PH_PAYLOAD: begin
          if (left_r == 16'd1) begin
            phase_nxt = check_enable_r ? slcd_pkg::PH_CHECK : slcd_pkg::PH_HUNT;
          end
        end
        slcd_pkg::PH_CHECK: phase_nxt = slcd_pkg::PH_HUNT;
        default: phase_nxt = sync_hit ? slcd_pkg::PH_LEN_HI : slcd_pkg::PH_HUNT;
      endcase
    end
  end

  // Datapath and results for the accepted byte.
  always_comb begin
    saw_first_nxt = saw_first_r;
    length_nxt    = length_r;
    left_nxt      = left_r;
    sum_nxt       = sum_r;
    push          = '0;
    if (in_fire) begin
      unique case (phase_r)
        slcd_pkg::PH_LEN_HI: begin
          length_nxt = {in_rx_byte, 8'h00};
          sum_nxt    = sum_r + in_rx_byte;
        end
        slcd_pkg::PH_LEN_LO: begin
          length_nxt = len_lo_val;
          left_nxt   = len_lo_val;
          sum_nxt    = sum_r + in_rx_byte;
          // zero length without checking closes the frame right here
          if (len_lo_val == 16'd0 && !check_enable_r) begin
            push.en0             = 1'b1;
            push.r0.kind         = slcd_pkg::KIND_END;
            push.r0.frame_ok     = 1'b1;
            push.r0.frame_length = len_lo_val;
            saw_first_nxt        = 1'b0;
          end
        end
        slcd_pkg::PH_PAYLOAD: begin
          push.en0             = 1'b1;
          push.r0.kind         = slcd_pkg::KIND_PAYLOAD;
          push.r0.payload_byte = in_rx_byte;
          push.r0.frame_length = length_r;
          sum_nxt              = sum_r + in_rx_byte;
          left_nxt             = left_r - 16'd1;
          // last payload byte without checking: end result follows in the same beat
          if (left_r == 16'd1 && !check_enable_r) begin
            push.en1             = 1'b1;
            push.r1.kind         = slcd_pkg::KIND_END;
            push.r1.frame_ok     = 1'b1;
            push.r1.frame_length = length_r;
            saw_first_nxt        = 1'b0;
          end
        end
        slcd_pkg::PH_CHECK: begin
          push.en0             = 1'b1;
          push.r0.kind         = slcd_pkg::KIND_END;
          push.r0.frame_ok     = (in_rx_byte == sum_r);
          push.r0.frame_length = length_r;
          saw_first_nxt        = 1'b0;
        end
        default: begin
          if (sync_hit) begin
            sum_nxt       = sync_first_r + sync_second_r;
            length_nxt    = 16'd0;
            left_nxt      = 16'd0;
            saw_first_nxt = 1'b0;
          end else begin
            saw_first_nxt = (in_rx_byte == sync_first_r);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= slcd_pkg::PH_HUNT;
      saw_first_r <= 1'b0;
      length_r    <= '0;
      left_r      <= '0;
      sum_r       <= '0;
    end else begin
      phase_r     <= phase_nxt;
      saw_first_r <= saw_first_nxt;
      length_r    <= length_nxt;
      left_r      <= left_nxt;
      sum_r       <= sum_nxt;
    end
  end

  // Result queue decouples the output stall from byte intake.
  slcd_out_fifo u_out_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .nearly_full (nearly_full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (head)
  );

  assign out_result_kind  = head.kind;
  assign out_payload_byte = head.payload_byte;
  assign out_frame_ok     = head.frame_ok;
  assign out_frame_length = head.frame_length;

  a_check_returns_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == slcd_pkg::PH_CHECK) |=> (phase_r == slcd_pkg::PH_HUNT))
    else $error("checksum beat did not return to hunting");

  a_last_payload_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == slcd_pkg::PH_PAYLOAD && left_r == 16'd1)
      |=> (phase_r != slcd_pkg::PH_PAYLOAD))
    else $error("payload phase outlived its length");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == slcd_pkg::KIND_END) |-> (out_payload_byte == 8'd0))
    else $error("end result carries a payload byte");

endmodule

// File: tb/sync_length_checksum_deframer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the sync/length/checksum deframer: sends byte beats,
// predicts payload and end-of-frame beats in step, and compares every result.
// Depends on slcd_pkg and the deframer RTL only.
module sync_length_checksum_deframer_tb;

  // Index that maps to no register; a write to it must leave everything alone.
  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam int         FILL_RANDOM = -1;
  localparam int         IDLE_PCT    = 27;
  // Upper bound on the whole run; the slowest legal run is far shorter.
  localparam longint     TIMEOUT_NS  = 2_000_000;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        cfg_wr_en        = 1'b0;
  logic [1:0]  cfg_index        = slcd_pkg::REG_SYNC_FIRST;
  logic [7:0]  cfg_data         = 8'h00;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte       = 8'h00;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic        out_result_kind;
  logic [7:0]  out_payload_byte;
  logic        out_frame_ok;
  logic [15:0] out_frame_length;

  // Register copies as the block should hold them.
  logic [7:0]  cur_sync_first  = slcd_pkg::SYNC_FIRST_RST;
  logic [7:0]  cur_sync_second = slcd_pkg::SYNC_SECOND_RST;
  logic        cur_check_en    = 1'b1;

  // Frame parser state, mirrored.
  slcd_pkg::phase_t st_phase     = slcd_pkg::PH_HUNT;
  logic             st_saw_first = 1'b0;
  logic [15:0]      st_len       = '0;
  logic [15:0]      st_left      = '0;
  logic [7:0]       st_sum       = '0;

  slcd_pkg::result_t due_results[$];
  slcd_pkg::result_t due_head;

  bit          quiet     = 1'b0;  // no random idling on either side while set
  int          hold_left = 0;     // receiver hold-off, counted down by the stall process
  int unsigned bytes_sent    = 0;
  int unsigned frames_sent   = 0;
  int unsigned beats_checked = 0;
  int unsigned settings_used = 1;
  int unsigned mismatches    = 0;

  sync_length_checksum_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_ok     (out_frame_ok),
    .out_frame_length (out_frame_length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: timeout with %0d results still due", due_results.size());
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Prediction: mirror the frame parser one accepted byte at a time.
  // ---------------------------------------------------------------------------
  task automatic push_result(input logic kind, input logic [7:0] pb, input logic ok);
    slcd_pkg::result_t r;
    r.kind         = kind;
    r.payload_byte = pb;
    r.frame_ok     = ok;
    r.frame_length = st_len;
    due_results.push_back(r);
  endtask

  // Payload complete: wait for the checksum, or close the frame right away.
  task automatic close_payload();
    if (cur_check_en) begin
      st_phase = slcd_pkg::PH_CHECK;
    end else begin
      push_result(slcd_pkg::KIND_END, 8'h00, 1'b1);
      st_phase     = slcd_pkg::PH_HUNT;
      st_saw_first = 1'b0;
    end
  endtask

  task automatic deframe_step(input logic [7:0] b);
    unique case (st_phase)
      slcd_pkg::PH_LEN_HI: begin
        st_len   = {b, 8'h00};
        st_sum   = st_sum + b;
        st_phase = slcd_pkg::PH_LEN_LO;
      end
      slcd_pkg::PH_LEN_LO: begin
        st_len[7:0] = b;
        st_sum      = st_sum + b;
        st_left     = st_len;
        if (st_left == 16'd0) close_payload();
        else st_phase = slcd_pkg::PH_PAYLOAD;
      end
      slcd_pkg::PH_PAYLOAD: begin
        push_result(slcd_pkg::KIND_PAYLOAD, b, 1'b0);
        st_sum  = st_sum + b;
        st_left = st_left - 16'd1;
        if (st_left == 16'd0) close_payload();
      end
      slcd_pkg::PH_CHECK: begin
        push_result(slcd_pkg::KIND_END, 8'h00, b == st_sum);
        st_phase     = slcd_pkg::PH_HUNT;
        st_saw_first = 1'b0;
      end
      default: begin
        // Hunt: slide one byte at a time over the stream.
        st_phase = slcd_pkg::PH_HUNT;
        if (st_saw_first && b == cur_sync_second) begin
          st_sum       = cur_sync_first + cur_sync_second;
          st_len       = '0;
          st_left      = '0;
          st_saw_first = 1'b0;
          st_phase     = slcd_pkg::PH_LEN_HI;
        end else begin
          st_saw_first = (b == cur_sync_first);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: compare each accepted result beat with the oldest one due.
  // Values read right after the edge are the ones the edge sampled.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing due (kind %b byte %h)",
                                  out_result_kind, out_payload_byte));
      end else begin
        due_head = due_results.pop_front();
        beats_checked++;
        if (out_result_kind !== due_head.kind)
          report_mismatch($sformatf("kind %b, want %b", out_result_kind, due_head.kind));
        if (out_payload_byte !== due_head.payload_byte)
          report_mismatch($sformatf("payload_byte %h, want %h",
                                    out_payload_byte, due_head.payload_byte));
        if (out_frame_ok !== due_head.frame_ok)
          report_mismatch($sformatf("frame_ok %b, want %b", out_frame_ok, due_head.frame_ok));
        if (out_frame_length !== due_head.frame_length)
          report_mismatch($sformatf("frame_length %h, want %h",
                                    out_frame_length, due_head.frame_length));
      end
    end
  end

  // Receiver: random stalls, none while quiet, and a forced hold-off when asked.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left  = hold_left - 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one byte beat and hold it until taken; valid stays high on return so
  // back-to-back beats need no second assignment in the same step.
  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_step(b);
    bytes_sent++;
  endtask

  // Write one register once the block has drained; drop valid first.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    unique case (idx)
      slcd_pkg::REG_SYNC_FIRST:   cur_sync_first  = data;
      slcd_pkg::REG_SYNC_SECOND:  cur_sync_second = data;
      slcd_pkg::REG_CHECK_ENABLE: cur_check_en    = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] s1, input logic [7:0] s2, input logic chk);
    write_reg(slcd_pkg::REG_SYNC_FIRST, s1);
    write_reg(slcd_pkg::REG_SYNC_SECOND, s2);
    write_reg(slcd_pkg::REG_CHECK_ENABLE, {7'd0, chk});
    settings_used++;
  endtask

  // Build one frame from the current registers. fill picks a constant payload
  // byte, or random bytes with FILL_RANDOM. corrupt spoils the checksum.
  task automatic send_frame(input logic [15:0] len, input bit corrupt, input int fill);
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [7:0]  spoil;
    int unsigned i;
    sum = cur_sync_first + cur_sync_second;
    send_byte(cur_sync_first);
    send_byte(cur_sync_second);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    sum = sum + len[15:8] + len[7:0];
    for (i = 0; i < len; i++) begin
      b = (fill == FILL_RANDOM) ? 8'($urandom) : 8'(fill);
      send_byte(b);
      sum = sum + b;
    end
    if (cur_check_en) begin
      spoil = 8'($urandom_range(255, 1));
      send_byte(corrupt ? sum + spoil : sum);
    end
    frames_sent++;
  endtask

  // Mostly well-formed frames with random content; the rest is line noise and
  // headers that break off after the first sync byte.
  task automatic run_random_mix(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    logic [15:0] len;
    logic [7:0]  b;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pick = $urandom_range(99);
        if (pick < 75) len = 16'($urandom_range(6));
        else if (pick < 97) len = 16'($urandom_range(40, 7));
        else len = 16'($urandom_range(300, 256));
        send_frame(len, $urandom_range(99) < 15, FILL_RANDOM);
      end else if (pick < 88) begin
        repeat ($urandom_range(4, 1)) begin
          b = 8'($urandom);
          send_byte(b);
        end
      end else begin
        send_byte(cur_sync_first);
        b = 8'($urandom);
        send_byte(b);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: good frames at the payload extremes, and a zero length one.
  task automatic test_reset_defaults();
    send_frame(16'd1, 1'b0, 8'h00);
    send_frame(16'd2, 1'b0, 8'hFF);
    send_frame(16'd0, 1'b0, 0);
  endtask

  // Bad checksum: payload beats still go out, end beat carries ok low.
  task automatic test_bad_checksum();
    send_frame(16'd2, 1'b1, FILL_RANDOM);
  endtask

  // First sync byte followed by junk, then a repeated first sync byte
  // that must still open a frame.
  task automatic test_false_sync();
    send_byte(cur_sync_first);
    send_byte(8'h00);
    send_byte(cur_sync_first);
    send_frame(16'd1, 1'b0, FILL_RANDOM);
  endtask

  // Checking off (written with the enable bit clear among set upper bits):
  // zero length closes on the low length byte, otherwise on the last payload byte.
  task automatic test_check_off();
    write_reg(slcd_pkg::REG_CHECK_ENABLE, 8'hFE);
    send_frame(16'd0, 1'b0, 0);
    send_frame(16'd1, 1'b0, FILL_RANDOM);
    write_reg(slcd_pkg::REG_CHECK_ENABLE, 8'h01);
  endtask

  // Register writes inside a frame, and a write to the unused index.
  task automatic test_mid_frame_write();
    send_byte(cur_sync_first);
    send_byte(cur_sync_second);
    send_byte(8'h00);
    send_byte(8'h02);
    // Enable is only read when the payload completes.
    write_reg(slcd_pkg::REG_CHECK_ENABLE, 8'h00);
    send_byte(8'h81);
    send_byte(8'h7F);
    write_reg(REG_UNUSED, 8'hFF);
    write_reg(slcd_pkg::REG_SYNC_FIRST, 8'h3C);
    send_byte(cur_sync_first);
    send_byte(cur_sync_second);
    // Sync registers only matter while hunting.
    write_reg(slcd_pkg::REG_SYNC_FIRST, 8'h00);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h33);
  endtask

  // Random traffic under several register settings, extremes included.
  task automatic test_config_sweep();
    set_config(8'h00, 8'hFF, 1'b1);
    run_random_mix(250);
    set_config(8'hFF, 8'h00, 1'b0);
    run_random_mix(250);
    set_config(8'h5A, 8'h5A, 1'b1);   // equal sync bytes
    run_random_mix(200);
    repeat (2) begin
      set_config(8'($urandom), 8'($urandom), 1'($urandom_range(1)));
      run_random_mix(200);
    end
    set_config(slcd_pkg::SYNC_FIRST_RST, slcd_pkg::SYNC_SECOND_RST, 1'b1);
    run_random_mix(250);
  endtask

  // Full-rate stretch with no gaps on either side.
  task automatic test_no_idle_stretch();
    quiet = 1'b1;
    run_random_mix(200);
    quiet = 1'b0;
  endtask

  // Hold the receiver off long enough that the result queue fills and the
  // block stalls its input while the sender keeps offering.
  task automatic test_receiver_holdoff();
    quiet     = 1'b1;
    hold_left = 80;
    send_frame(16'd40, 1'b0, FILL_RANDOM);
    send_frame(16'd0, 1'b0, 0);
    quiet = 1'b0;
  endtask

  // A frame longer than 255 bytes, so both length bytes count, at full rate.
  task automatic test_long_frame();
    quiet = 1'b1;
    send_frame(16'd260, 1'b0, FILL_RANDOM);
    quiet = 1'b0;
  endtask

  initial begin
    int unsigned waited;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_bad_checksum();
    test_false_sync();
    test_check_off();
    test_mid_frame_write();
    test_config_sweep();
    test_no_idle_stretch();
    test_receiver_holdoff();
    test_long_frame();

    // Drain, then keep clocking after the drain to show any stray beat.
    in_valid <= 1'b0;
    waited = 0;
    while (due_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));

    $display("summary: %0d bytes in %0d built frames plus noise, %0d result beats checked",
             bytes_sent, frames_sent, beats_checked);
    $display("summary: %0d register settings, queue fill and full-rate stretch exercised",
             settings_used);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/slcd_pkg.sv
sv/slcd_out_fifo.sv
sv/sync_length_checksum_deframer.sv
tb/sync_length_checksum_deframer_tb.sv
